>>> src/assert_macros.svh
// Assertion macros shared by the splitter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_RST(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");
`else
`define ASSERT_RST(lbl, clk, rst_n, prop)
`define ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

>>> src/grrs_pkg.sv
// Types and codes shared by the GOP round-robin splitter.
package grrs_pkg;

  typedef enum logic [1:0] {
    OP_MEDIA = 2'd0,
    OP_RESET = 2'd1,
    OP_END   = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    PK_DATA  = 2'd0,
    PK_RESET = 2'd1,
    PK_END   = 2'd2
  } pkt_kind_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SYNTH,
    S_DATA,
    S_LOCAL,
    S_BCAST,
    S_ERR
  } state_e;

  // codec ranges
  localparam logic [2:0] CODEC_MVC  = 3'd2;
  localparam logic [2:0] CODEC_MP4V = 3'd5;

  // frame kinds
  localparam logic [2:0] FK_PPS  = 3'd1;
  localparam logic [2:0] FK_IDR  = 3'd3;
  localparam logic [2:0] FK_IPIC = 3'd4;

  // register index, taken from paddr[2]
  localparam logic CFG_IDX_SPLIT = 1'b0;
  localparam logic CFG_IDX_SYNC  = 1'b1;

  localparam int unsigned ADDR_W = 3;

  typedef struct packed {
    logic [4:0] split_count;
    logic       sync_wr;
    logic       sync_val;
  } cfg_t;

endpackage

>>> src/grrs_cnt_mem.sv
// Per-lane unit counter memory: sync read, valid bits, write forwarding.
`include "assert_macros.svh"
module grrs_cnt_mem #(
  parameter int unsigned MAX_LANES = 16,
  parameter int unsigned LANE_W    = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [LANE_W-1:0] rd_addr_i,
  input  logic              we_i,
  input  logic [LANE_W-1:0] wr_addr_i,
  input  logic [31:0]       wr_data_i,
  output logic [31:0]       rd_data_o
);
  logic [31:0]          mem_q [MAX_LANES];
  logic [MAX_LANES-1:0] vld_q;
  logic [31:0]          mem_rd_q;
  logic                 vld_rd_q;
  logic                 fwd_q;
  logic [31:0]          fwd_data_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    mem_rd_q   <= mem_q[rd_addr_i];
    fwd_data_q <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      vld_rd_q <= 1'b0;
      fwd_q    <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      vld_rd_q <= vld_q[rd_addr_i];
      // same-entry write at the read edge: the array still holds the old word
      fwd_q    <= we_i && (wr_addr_i == rd_addr_i);
    end
  end

  assign rd_data_o = fwd_q ? fwd_data_q : (vld_rd_q ? mem_rd_q : 32'd0);

  `ASSERT_RST(fwd_after_write, clk_i, rst_ni, fwd_q |-> $past(we_i))

endmodule

>>> src/grrs_seq.sv
// Splitter sequencer: item decode, result steps, counter update, output register.
`include "assert_macros.svh"
module grrs_seq #(
  parameter int unsigned MAX_LANES = 16,
  parameter int unsigned LANE_W    = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  grrs_pkg::cfg_t    cfg_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        op_i,
  input  logic [2:0]        codec_i,
  input  logic [2:0]        frame_kind_i,
  input  logic              is_key_i,
  input  logic [31:0]       frame_number_i,
  input  logic [15:0]       base_route_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [16:0]       out_route_o,
  output logic [31:0]       unit_number_o,
  output logic [1:0]        packet_kind_o,
  output logic              synthesized_o,
  output logic              codec_error_o,
  output logic              last_of_run_o,
  output logic [LANE_W-1:0] mem_rd_addr_o,
  output logic              mem_we_o,
  output logic [LANE_W-1:0] mem_wr_addr_o,
  output logic [31:0]       mem_wr_data_o,
  input  logic [31:0]       mem_rd_data_i
);
  import grrs_pkg::*;

  localparam int unsigned TOT_W = $clog2(MAX_LANES + 1);

  state_e            state_q, state_d;
  logic [LANE_W-1:0] lane_q, lane_d;
  logic [LANE_W-1:0] res_lane_q, res_lane_d;
  logic [31:0]       prev_frame_q, prev_frame_d;
  logic              prev_valid_q, prev_valid_d;
  logic              sync_active_q, sync_active_d;
  logic [15:0]       base_q, base_d;
  pkt_kind_e         kind_q, kind_d;

  logic              out_valid_q;
  logic [16:0]       out_route_q, out_route_d;
  logic [31:0]       out_unit_q, out_unit_d;
  pkt_kind_e         out_kind_q, out_kind_d;
  logic              out_synth_q, out_synth_d;
  logic              out_err_q, out_err_d;
  logic              out_last_q, out_last_d;
  logic              out_ld;
  logic              out_free;

  logic [TOT_W-1:0]  total;
  logic [LANE_W:0]   lane_nx;
  logic [LANE_W-1:0] lane_adv;
  logic              is_avc, is_mpv, is_param, is_bound, sync_after, bcast_last;

  // lane count clamped to 1..MAX_LANES
  always_comb begin
    if (cfg_i.split_count == 5'd0) begin
      total = TOT_W'(1);
    end else if (32'(cfg_i.split_count) > 32'(MAX_LANES)) begin
      total = TOT_W'(MAX_LANES);
    end else begin
      total = TOT_W'(cfg_i.split_count);
    end
  end

  assign lane_nx    = {1'b0, lane_q} + (LANE_W + 1)'(1);
  assign lane_adv   = (32'(lane_nx) >= 32'(total)) ? '0 : lane_nx[LANE_W-1:0];
  assign bcast_last = (32'(res_lane_q) + 32'd1) >= 32'(total);

  assign is_avc     = codec_i <= CODEC_MVC;
  assign is_mpv     = (codec_i > CODEC_MVC) && (codec_i <= CODEC_MP4V);
  assign is_param   = (frame_kind_i >= FK_PPS) && (frame_kind_i <= FK_IDR);
  assign is_bound   = prev_valid_q && (prev_frame_q != 32'd0) &&
                      (frame_number_i != prev_frame_q);
  assign sync_after = is_param ? 1'b0 : sync_active_q;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d       = state_q;
    lane_d        = lane_q;
    res_lane_d    = res_lane_q;
    prev_frame_d  = prev_frame_q;
    prev_valid_d  = prev_valid_q;
    sync_active_d = sync_active_q;
    base_d        = base_q;
    kind_d        = kind_q;
    out_ld        = 1'b0;
    mem_we_o      = 1'b0;
    out_route_d   = 17'(base_q) + 17'(res_lane_q);
    out_unit_d    = mem_rd_data_i;
    out_kind_d    = PK_DATA;
    out_synth_d   = 1'b0;
    out_err_d     = 1'b0;
    out_last_d    = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          base_d     = base_route_i;
          kind_d     = (op_i == OP_END) ? PK_END : PK_RESET;
          res_lane_d = lane_q;
          unique case (op_i)
            OP_MEDIA: begin
              if (is_avc) begin
                sync_active_d = sync_after;
                prev_frame_d  = frame_number_i;
                prev_valid_d  = 1'b1;
                if (is_param && is_bound) begin
                  state_d = S_SYNTH;
                end else if (!(sync_after && !is_key_i)) begin
                  state_d = S_DATA;
                end
              end else if (is_mpv) begin
                prev_frame_d = frame_number_i;
                prev_valid_d = 1'b1;
                state_d      = ((frame_kind_i == FK_IPIC) && is_bound) ? S_SYNTH : S_DATA;
              end else begin
                state_d = S_ERR;
              end
            end
            OP_RESET, OP_END: state_d = S_LOCAL;
            OP_NONE:          state_d = S_IDLE;
          endcase
        end
      end
      S_SYNTH: begin
        if (out_free) begin
          out_ld      = 1'b1;
          mem_we_o    = 1'b1;
          out_kind_d  = PK_RESET;
          out_synth_d = 1'b1;
          lane_d      = lane_adv;
          res_lane_d  = lane_adv;
          state_d     = S_DATA;
        end
      end
      S_DATA: begin
        if (out_free) begin
          out_ld     = 1'b1;
          mem_we_o   = 1'b1;
          out_last_d = 1'b1;
          state_d    = S_IDLE;
        end
      end
      S_LOCAL: begin
        if (out_free) begin
          out_ld     = 1'b1;
          mem_we_o   = 1'b1;
          out_kind_d = PK_RESET;
          res_lane_d = '0;
          state_d    = S_BCAST;
        end
      end
      S_BCAST: begin
        if (out_free) begin
          out_ld     = 1'b1;
          mem_we_o   = 1'b1;
          out_kind_d = kind_q;
          if (bcast_last) begin
            out_last_d   = 1'b1;
            prev_valid_d = 1'b0;
            lane_d       = lane_adv;
            state_d      = S_IDLE;
          end else begin
            res_lane_d = res_lane_q + LANE_W'(1);
          end
        end
      end
      S_ERR: begin
        if (out_free) begin
          out_ld      = 1'b1;
          out_route_d = '0;
          out_unit_d  = '0;
          out_err_d   = 1'b1;
          out_last_d  = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (cfg_i.sync_wr) begin
      sync_active_d = cfg_i.sync_val;
    end
  end

  assign mem_rd_addr_o = res_lane_d;
  assign mem_wr_addr_o = res_lane_q;
  assign mem_wr_data_o = mem_rd_data_i + 32'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      lane_q        <= '0;
      res_lane_q    <= '0;
      prev_frame_q  <= '0;
      prev_valid_q  <= 1'b0;
      sync_active_q <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      lane_q        <= lane_d;
      res_lane_q    <= res_lane_d;
      prev_frame_q  <= prev_frame_d;
      prev_valid_q  <= prev_valid_d;
      sync_active_q <= sync_active_d;
      if (out_ld) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    base_q <= base_d;
    kind_q <= kind_d;
    if (out_ld) begin
      out_route_q <= out_route_d;
      out_unit_q  <= out_unit_d;
      out_kind_q  <= out_kind_d;
      out_synth_q <= out_synth_d;
      out_err_q   <= out_err_d;
      out_last_q  <= out_last_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_route_o   = out_route_q;
  assign unit_number_o = out_unit_q;
  assign packet_kind_o = out_kind_q;
  assign synthesized_o = out_synth_q;
  assign codec_error_o = out_err_q;
  assign last_of_run_o = out_last_q;

  `ASSERT_ALWAYS(err_is_last, clk_i, (out_valid_q && out_err_q) |-> out_last_q)
  `ASSERT_RST(out_from_busy, clk_i, rst_ni, $rose(out_valid_q) |-> $past(state_q != S_IDLE))
  `ASSERT_RST(bcast_in_range, clk_i, rst_ni, (state_q == S_BCAST) |-> (32'(res_lane_q) < 32'(total)))

endmodule

>>> src/gop_round_robin_splitter.sv
// GOP round-robin splitter top level: register port, sequencer, counter memory.
//
//  port group   dir   handshake               payload
//  in           in    in_valid_i/in_stall_o   op, codec, frame_kind, is_key, frame_number,
//                                             base_route
//  out          out   out_valid_o/out_stall_i out_route, unit_number, packet_kind,
//                                             synthesized, codec_error, last_of_run
//  cfg          in    psel/penable/pready     paddr, pwdata, pwrite, prdata
//
// An item is accepted, then its results are produced one after another, each a
// read-increment-write of one lane counter in the single memory (media 1 or 2
// results, reset/end 1 + lane count).
// Dropped items and op 3 give no result, an unsupported codec one error result with no counter write.
// Counters read as zero after reset through per-lane valid bits; no clearing pass.
// out_stall_i holds the sequencer; no new item is taken until the last result is
// in the output register.
module gop_round_robin_splitter #(
  parameter int unsigned MAX_LANES = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [grrs_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    op_i,
  input  logic [2:0]                    codec_i,
  input  logic [2:0]                    frame_kind_i,
  input  logic                          is_key_i,
  input  logic [31:0]                   frame_number_i,
  input  logic [15:0]                   base_route_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [16:0]                   out_route_o,
  output logic [31:0]                   unit_number_o,
  output logic [1:0]                    packet_kind_o,
  output logic                          synthesized_o,
  output logic                          codec_error_o,
  output logic                          last_of_run_o
);
  import grrs_pkg::*;

  localparam int unsigned LANE_W = (MAX_LANES > 1) ? $clog2(MAX_LANES) : 1;

  logic [4:0]        split_q;
  logic              sync_q;
  logic              cfg_wr;
  cfg_t              cfg;
  logic [LANE_W-1:0] mem_rd_addr;
  logic              mem_we;
  logic [LANE_W-1:0] mem_wr_addr;
  logic [31:0]       mem_wr_data;
  logic [31:0]       mem_rd_data;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      split_q <= 5'd1;
      sync_q  <= 1'b0;
    end else if (cfg_wr) begin
      if (paddr[2] == CFG_IDX_SPLIT) begin
        split_q <= pwdata[4:0];
      end else begin
        sync_q <= pwdata[0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == CFG_IDX_SYNC) begin
      prdata = {31'd0, sync_q};
    end else begin
      prdata = {27'd0, split_q};
    end
  end

  assign cfg.split_count = split_q;
  assign cfg.sync_wr     = cfg_wr && (paddr[2] == CFG_IDX_SYNC);
  assign cfg.sync_val    = pwdata[0];

  grrs_seq #(
    .MAX_LANES(MAX_LANES),
    .LANE_W   (LANE_W)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .op_i          (op_i),
    .codec_i       (codec_i),
    .frame_kind_i  (frame_kind_i),
    .is_key_i      (is_key_i),
    .frame_number_i(frame_number_i),
    .base_route_i  (base_route_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_route_o   (out_route_o),
    .unit_number_o (unit_number_o),
    .packet_kind_o (packet_kind_o),
    .synthesized_o (synthesized_o),
    .codec_error_o (codec_error_o),
    .last_of_run_o (last_of_run_o),
    .mem_rd_addr_o (mem_rd_addr),
    .mem_we_o      (mem_we),
    .mem_wr_addr_o (mem_wr_addr),
    .mem_wr_data_o (mem_wr_data),
    .mem_rd_data_i (mem_rd_data)
  );

  grrs_cnt_mem #(
    .MAX_LANES(MAX_LANES),
    .LANE_W   (LANE_W)
  ) u_cnt_mem (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_addr_i(mem_rd_addr),
    .we_i     (mem_we),
    .wr_addr_i(mem_wr_addr),
    .wr_data_i(mem_wr_data),
    .rd_data_o(mem_rd_data)
  );

endmodule

>>> dv/gop_round_robin_splitter_tb.sv
// Self-checking testbench for the GOP round-robin splitter.
module gop_round_robin_splitter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import grrs_pkg::*;

  localparam logic [2:0] C_AVC    = 3'd0;
  localparam logic [2:0] C_SVC    = 3'd1;
  localparam logic [2:0] C_MP1V   = 3'd3;
  localparam logic [2:0] C_MP2V   = 3'd4;
  localparam logic [2:0] C_BAD_LO = 3'd6;
  localparam logic [2:0] C_BAD_HI = 3'd7;
  localparam logic [2:0] FK_OTHER = 3'd0;
  localparam logic [2:0] FK_SPS   = 3'd2;

  localparam int unsigned LANES_MAX    = 16;
  localparam int unsigned SETTLE       = 6;
  localparam int unsigned HOLD_CYCLES  = 150;
  localparam int unsigned IDLE_LIMIT   = 1000;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned PHASE_ITEMS  = 34;

  typedef struct packed {
    op_e         op;
    logic [2:0]  codec;
    logic [2:0]  fkind;
    logic        key;
    logic [31:0] fnum;
    logic [15:0] route;
  } pkt_t;

  typedef struct packed {
    logic [16:0] route;
    logic [31:0] unit;
    pkt_kind_e   kind;
    logic        synth;
    logic        err;
    logic        last;
  } res_t;

  typedef struct packed {
    logic        is_reg;
    logic        reg_idx;
    logic [31:0] reg_val;
    pkt_t        pkt;
    logic        pinned;
    res_t        want;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic psel, penable, pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;
  logic in_valid_i, in_stall_o;
  logic [1:0] op_i;
  logic [2:0] codec_i, frame_kind_i;
  logic is_key_i;
  logic [31:0] frame_number_i;
  logic [15:0] base_route_i;
  logic out_valid_o, out_stall_i;
  logic [16:0] out_route_o;
  logic [31:0] unit_number_o;
  logic [1:0] packet_kind_o;
  logic synthesized_o, codec_error_o, last_of_run_o;

  logic pin_now;
  res_t pin_want;

  // predictor state
  logic [4:0]  split_cfg = 5'd1;
  logic        sync_now = 1'b0;
  int unsigned lane_now = 0;
  logic [31:0] last_frame = '0;
  logic        frame_seen = 1'b0;
  logic [31:0] lane_units [LANES_MAX];

  res_t new_units [$];
  res_t pending_units [$];
  int unsigned bad_units = 0;
  int unsigned idle_cycles = 0;
  int unsigned stall_left = 0;
  logic tx_burst = 1'b0;
  logic rx_burst = 1'b0;
  logic hold_due = 1'b0;

  // random stream state
  logic [2:0]  codec_run = C_AVC;
  logic [31:0] fn_run = 32'd1;

  gop_round_robin_splitter uut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_stall_o, .op_i, .codec_i, .frame_kind_i, .is_key_i,
    .frame_number_i, .base_route_i, .out_valid_o, .out_stall_i, .out_route_o,
    .unit_number_o, .packet_kind_o, .synthesized_o, .codec_error_o, .last_of_run_o
  );

  always #5 clk_i = ~clk_i;

  function automatic int unsigned lanes_used();
    if (split_cfg < 1) return 1;
    if (split_cfg > LANES_MAX) return LANES_MAX;
    return int'(split_cfg);
  endfunction

  function automatic void next_lane();
    int unsigned n;
    n = lane_now + 1;
    lane_now = (n >= lanes_used()) ? 0 : n;
  endfunction

  function automatic logic gop_edge(logic [31:0] fn);
    return frame_seen && last_frame != 0 && fn != last_frame;
  endfunction

  function automatic void put_unit(logic [15:0] route, int unsigned lane, pkt_kind_e kind,
                                   logic synth, logic last);
    res_t r;
    int unsigned l;
    l = lane % LANES_MAX;
    r = '0;
    r.route = {1'b0, route} + 17'(l);
    r.unit = lane_units[l];
    r.kind = kind;
    r.synth = synth;
    r.last = last;
    lane_units[l] = lane_units[l] + 32'd1;
    new_units.push_back(r);
  endfunction

  function automatic void route_packet(pkt_t p);
    int unsigned n;
    res_t r;
    new_units.delete();
    if (p.op == OP_NONE) return;
    if (p.op == OP_RESET || p.op == OP_END) begin
      n = lanes_used();
      put_unit(p.route, lane_now, PK_RESET, 1'b0, 1'b0);
      for (int unsigned i = 0; i < n; i++)
        put_unit(p.route, i, (p.op == OP_END) ? PK_END : PK_RESET, 1'b0, i == n - 1);
      frame_seen = 1'b0;
      next_lane();
      return;
    end
    if (p.codec <= CODEC_MVC) begin
      if (p.fkind >= FK_PPS && p.fkind <= FK_IDR) begin
        sync_now = 1'b0;
        if (gop_edge(p.fnum)) begin
          put_unit(p.route, lane_now, PK_RESET, 1'b1, 1'b0);
          next_lane();
        end
      end
      if (sync_now && !p.key) begin
        last_frame = p.fnum;
        frame_seen = 1'b1;
        return;
      end
    end else if (p.codec <= CODEC_MP4V) begin
      if (p.fkind == FK_IPIC && gop_edge(p.fnum)) begin
        put_unit(p.route, lane_now, PK_RESET, 1'b1, 1'b0);
        next_lane();
      end
    end else begin
      r = '0;
      r.err = 1'b1;
      r.last = 1'b1;
      new_units.push_back(r);
      return;
    end
    last_frame = p.fnum;
    frame_seen = 1'b1;
    put_unit(p.route, lane_now, PK_DATA, 1'b0, 1'b1);
  endfunction

  function automatic pkt_t next_random_pkt();
    pkt_t p;
    int unsigned r;
    p.op = OP_MEDIA;
    p.codec = codec_run;
    p.fkind = FK_OTHER;
    p.key = ($urandom_range(0, 9) == 0);
    p.fnum = fn_run;
    p.route = 16'($urandom_range(0, 16'hFFFF));
    r = $urandom_range(0, 99);
    if (r < 13) begin
      if (r < 3) p.op = OP_RESET;
      else if (r < 6) p.op = OP_END;
      else if (r < 8) p.op = OP_NONE;
      p.codec = (r < 8) ? 3'($urandom_range(C_AVC, C_BAD_HI)) :
                          3'($urandom_range(C_BAD_LO, C_BAD_HI));
      p.fkind = 3'($urandom_range(FK_OTHER, FK_IPIC));
      p.key = 1'($urandom_range(0, 1));
      p.fnum = $urandom;
      return p;
    end
    if ($urandom_range(0, 19) == 0) codec_run = 3'($urandom_range(C_AVC, CODEC_MP4V));
    r = $urandom_range(0, 99);
    if (r < 30) fn_run = fn_run + 32'd1;
    else if (r < 33) fn_run = $urandom;
    else if (r < 35) fn_run = '0;
    p.codec = codec_run;
    p.fnum = fn_run;
    r = $urandom_range(0, 99);
    if (r < 30) begin
      p.key = 1'b1;
      p.fkind = (codec_run <= CODEC_MVC) ? 3'($urandom_range(FK_PPS, FK_IDR)) : FK_IPIC;
    end else if (r < 40) begin
      p.fkind = 3'($urandom_range(FK_OTHER, FK_IPIC));
    end
    return p;
  endfunction

  function automatic row_t pkt_row(op_e op, logic [2:0] codec, logic [2:0] fkind, logic key,
                                   logic [31:0] fnum, logic [15:0] route);
    row_t w;
    w = '0;
    w.pkt.op = op;
    w.pkt.codec = codec;
    w.pkt.fkind = fkind;
    w.pkt.key = key;
    w.pkt.fnum = fnum;
    w.pkt.route = route;
    return w;
  endfunction

  function automatic row_t reg_row(logic idx, logic [31:0] val);
    row_t w;
    w = '0;
    w.is_reg = 1'b1;
    w.reg_idx = idx;
    w.reg_val = val;
    return w;
  endfunction

  function automatic row_t pinned_row(row_t w, logic [16:0] route, logic err);
    w.pinned = 1'b1;
    w.want = '0;
    w.want.route = route;
    w.want.kind = PK_DATA;
    w.want.err = err;
    w.want.last = 1'b1;
    return w;
  endfunction

  task automatic report(string what, res_t w, res_t g);
    bad_units++;
    if (bad_units <= 10)
      $display("%s: exp %h %h %0d %b %b %b | got %h %h %0d %b %b %b",
               what, w.route, w.unit, w.kind, w.synth, w.err, w.last,
               g.route, g.unit, g.kind, g.synth, g.err, g.last);
  endtask

  task automatic cfg_write(logic idx, logic [31:0] val);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_units.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic offer(pkt_t p, logic pinned, res_t want);
    int unsigned gap;
    if ($urandom_range(0, 11) == 0) tx_burst = !tx_burst;
    gap = tx_burst ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    op_i <= p.op;
    codec_i <= p.codec;
    frame_kind_i <= p.fkind;
    is_key_i <= p.key;
    frame_number_i <= p.fnum;
    base_route_i <= p.route;
    pin_now <= pinned;
    pin_want <= want;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
  endtask

  always @(posedge clk_i) begin : scoreboard
    pkt_t p;
    res_t got, want;
    logic moved;
    if (rst_ni === 1'b1) begin
      moved = 1'b0;
      if (psel && penable && pwrite && pready) begin
        moved = 1'b1;
        if (paddr[2] == CFG_IDX_SPLIT) begin
          split_cfg = pwdata[4:0];
        end else begin
          sync_now = pwdata[0];
        end
      end
      if (in_valid_i && !in_stall_o) begin
        moved = 1'b1;
        p.op = op_e'(op_i);
        p.codec = codec_i;
        p.fkind = frame_kind_i;
        p.key = is_key_i;
        p.fnum = frame_number_i;
        p.route = base_route_i;
        route_packet(p);
        if (pin_now) pending_units.push_back(pin_want);
        else foreach (new_units[j]) pending_units.push_back(new_units[j]);
      end
      if (out_valid_o && !out_stall_i) begin
        moved = 1'b1;
        got.route = out_route_o;
        got.unit = unit_number_o;
        got.kind = pkt_kind_e'(packet_kind_o);
        got.synth = synthesized_o;
        got.err = codec_error_o;
        got.last = last_of_run_o;
        if (pending_units.size() == 0) begin
          report("unexpected item", '0, got);
        end else begin
          want = pending_units.pop_front();
          if (got.route !== want.route || got.unit !== want.unit || got.kind !== want.kind ||
              got.synth !== want.synth || got.err !== want.err || got.last !== want.last)
            report("mismatch", want, got);
        end
        if ($urandom_range(0, 15) == 0) rx_burst = !rx_burst;
        stall_left = rx_burst ? 0 : $urandom_range(0, 6);
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin : receiver
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_due) begin
        hold_due = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      if (stall_left != 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    row_t rows [$];
    logic [4:0] split_v;
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid_i = 1'b0;
    op_i = OP_MEDIA;
    codec_i = C_AVC;
    frame_kind_i = FK_OTHER;
    is_key_i = 1'b0;
    frame_number_i = '0;
    base_route_i = '0;
    pin_now = 1'b0;
    pin_want = '0;
    foreach (lane_units[l]) lane_units[l] = '0;

    rows.push_back(pinned_row(pkt_row(OP_MEDIA, C_AVC, FK_OTHER, 1'b0, 32'd0, 16'hFFFF),
                              17'h0FFFF, 1'b0));
    rows.push_back(pkt_row(OP_MEDIA, C_AVC, FK_SPS, 1'b1, 32'd1, 16'h0000));
    rows.push_back(pkt_row(OP_MEDIA, C_AVC, FK_IDR, 1'b1, 32'd2, 16'h1234));
    rows.push_back(reg_row(CFG_IDX_SPLIT, 32'd16));
    rows.push_back(pkt_row(OP_MEDIA, C_SVC, FK_PPS, 1'b1, 32'd3, 16'h8000));
    rows.push_back(pkt_row(OP_MEDIA, CODEC_MVC, FK_OTHER, 1'b0, 32'd3, 16'h0001));
    rows.push_back(pkt_row(OP_MEDIA, C_MP1V, FK_IPIC, 1'b1, 32'd4, 16'h0002));
    rows.push_back(pkt_row(OP_MEDIA, C_MP2V, FK_IPIC, 1'b1, 32'd4, 16'h0003));
    rows.push_back(pkt_row(OP_MEDIA, CODEC_MP4V, FK_IPIC, 1'b1, 32'hFFFF_FFFF, 16'hFFFF));
    rows.push_back(pinned_row(pkt_row(OP_MEDIA, C_BAD_LO, FK_OTHER, 1'b0, 32'd5, 16'h0042),
                              17'h0, 1'b1));
    rows.push_back(pinned_row(pkt_row(OP_MEDIA, C_BAD_HI, FK_IPIC, 1'b1, 32'hFFFF_FFFF,
                                      16'hFFFF), 17'h0, 1'b1));
    rows.push_back(pkt_row(OP_NONE, C_AVC, FK_IDR, 1'b1, 32'd6, 16'h0005));
    rows.push_back(pkt_row(OP_RESET, C_AVC, FK_OTHER, 1'b0, 32'd7, 16'hFFFF));
    rows.push_back(pkt_row(OP_END, C_MP2V, FK_OTHER, 1'b0, 32'd8, 16'h0000));
    // lane left above the new count is used once more, then wraps
    rows.push_back(reg_row(CFG_IDX_SPLIT, 32'd2));
    rows.push_back(pkt_row(OP_MEDIA, C_MP1V, FK_OTHER, 1'b0, 32'd20, 16'h0100));
    rows.push_back(pkt_row(OP_MEDIA, C_MP1V, FK_IPIC, 1'b1, 32'd21, 16'h0101));
    rows.push_back(reg_row(CFG_IDX_SPLIT, 32'd0));
    rows.push_back(pkt_row(OP_MEDIA, CODEC_MP4V, FK_IPIC, 1'b1, 32'd22, 16'h0102));
    rows.push_back(reg_row(CFG_IDX_SYNC, 32'd1));
    rows.push_back(pkt_row(OP_MEDIA, C_AVC, FK_OTHER, 1'b0, 32'd30, 16'h0200));
    rows.push_back(pkt_row(OP_MEDIA, C_MP2V, FK_OTHER, 1'b0, 32'd31, 16'h0201));
    rows.push_back(pkt_row(OP_MEDIA, C_SVC, FK_OTHER, 1'b1, 32'd32, 16'h0202));
    rows.push_back(pkt_row(OP_MEDIA, CODEC_MVC, FK_IDR, 1'b0, 32'd33, 16'h0203));
    rows.push_back(pkt_row(OP_MEDIA, C_AVC, FK_OTHER, 1'b0, 32'd33, 16'h0204));
    rows.push_back(reg_row(CFG_IDX_SYNC, 32'd0));
    rows.push_back(pkt_row(OP_RESET, C_SVC, FK_OTHER, 1'b0, 32'd34, 16'h7FFF));

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (rows[r]) begin
      if (rows[r].is_reg) cfg_write(rows[r].reg_idx, rows[r].reg_val);
      else offer(rows[r].pkt, rows[r].pinned, rows[r].want);
    end

    for (int unsigned ph = 0; ph < 6; ph++) begin
      case (ph)
        0: split_v = 5'd16;
        1: split_v = 5'd1;
        2: split_v = 5'd3;
        3: split_v = 5'd0;
        4: split_v = 5'd31;
        default: split_v = 5'($urandom_range(1, LANES_MAX));
      endcase
      cfg_write(CFG_IDX_SPLIT, {27'd0, split_v});
      cfg_write(CFG_IDX_SYNC, (ph == 5) ? $urandom_range(0, 1) : ph % 2);
      if (ph == 2) hold_due = 1'b1;
      for (int unsigned k = 0; k < PHASE_ITEMS; k++) offer(next_random_pkt(), 1'b0, '0);
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_units.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (bad_units == 0 && pending_units.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
